// File: hdl/alpha_run_length_encoder_assert.svh
// Assertion macros shared by the alpha run-length encoder modules.
// Each macro expects signals named clk and arst_n in the using module.
`ifndef ALPHA_RUN_LENGTH_ENCODER_ASSERT_SVH
`define ALPHA_RUN_LENGTH_ENCODER_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define ALRE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("alre assertion failed");

// Next-cycle implication, checked while out of reset.
`define ALRE_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("alre assertion failed");

`endif

// File: hdl/alre_pkg.sv
// ----------------------------------------------------------------------------
// alre_pkg: shared types and constants of the alpha run-length encoder
// Holds the pixel and result word types, the result kinds and the sizes.
// ----------------------------------------------------------------------------
package alre_pkg;

	localparam int MAX_RUN = 256;
	localparam int RUN_W   = $clog2(MAX_RUN + 1);
	localparam int MAX_RES = 4;
	localparam int CNT_W   = $clog2(MAX_RES + 1);
	localparam int IDX_W   = $clog2(MAX_RES);
	localparam int ADDR_W  = 32;
	localparam int PAY_W   = 24;
	localparam int ROW_W   = 16;
	localparam int CODE_W  = 8;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_RGB    = 2'd1,
		KIND_ROW    = 2'd2,
		KIND_TOTAL  = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] pixel_alpha;
		logic       row_end;
		logic       image_end;
	} pixel_t;

	typedef struct packed {
		kind_t               kind;
		logic [ADDR_W-1:0]   address;
		logic [PAY_W-1:0]    payload;
		logic [ADDR_W-1:0]   offset_value;
	} res_t;

	typedef res_t res_list_t [MAX_RES];

endpackage

// File: hdl/alre_core.sv
// ----------------------------------------------------------------------------
// alre_core: run tracking and result list of the alpha run-length encoder
// Holds the run and pointer state and builds the words that one pixel causes.
// ----------------------------------------------------------------------------
`include "alpha_run_length_encoder_assert.svh"

module alre_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  alre_pkg::pixel_t               pix,
	input  logic                           advance,
	output alre_pkg::res_list_t            list,
	output logic [alre_pkg::CNT_W-1:0]     count
);

	logic [7:0]                    ra_q;
	logic [alre_pkg::RUN_W-1:0]    rl_q;
	logic [alre_pkg::ADDR_W-1:0]   rs_q;
	logic [alre_pkg::ADDR_W-1:0]   wp_q;
	logic [alre_pkg::ROW_W-1:0]    row_q;
	logic                          ars_q;

	logic                          close1;
	logic [alre_pkg::RUN_W-1:0]    rl1;
	logic [alre_pkg::RUN_W-1:0]    rl3;
	logic [7:0]                    ra2;
	logic [alre_pkg::ADDR_W-1:0]   rs2;
	logic [alre_pkg::ADDR_W-1:0]   wp2;
	logic [alre_pkg::ADDR_W-1:0]   wp3;
	logic                          opaque;
	logic                          row_done;

	alre_pkg::res_t                cand [5];
	logic [4:0]                    cand_en;

	always_comb begin
		close1   = (rl_q != '0) && ((pix.pixel_alpha != ra_q) ||
			(rl_q >= alre_pkg::RUN_W'(alre_pkg::MAX_RUN)));
		rl1      = close1 ? '0 : rl_q;
		ra2      = (rl1 == '0) ? pix.pixel_alpha : ra_q;
		rs2      = (rl1 == '0) ? wp_q : rs_q;
		wp2      = (rl1 == '0) ? wp_q + alre_pkg::ADDR_W'(2) : wp_q;
		rl3      = rl1 + alre_pkg::RUN_W'(1);
		opaque   = pix.pixel_alpha != 8'd0;
		wp3      = opaque ? wp2 + alre_pkg::ADDR_W'(3) : wp2;
		row_done = pix.row_end | pix.image_end;
	end

	// Candidate words in the order they leave the block.
	always_comb begin
		cand[0].kind         = alre_pkg::KIND_ROW;
		cand[0].address      = alre_pkg::ADDR_W'(row_q);
		cand[0].payload      = wp_q[alre_pkg::PAY_W-1:0];
		cand[0].offset_value = wp_q;

		cand[1].kind         = alre_pkg::KIND_HEADER;
		cand[1].address      = rs_q;
		cand[1].payload      = alre_pkg::PAY_W'({ra_q, alre_pkg::CODE_W'(rl_q)});
		cand[1].offset_value = '0;

		cand[2].kind         = alre_pkg::KIND_RGB;
		cand[2].address      = wp2;
		cand[2].payload      = {pix.red, pix.green, pix.blue};
		cand[2].offset_value = '0;

		cand[3].kind         = alre_pkg::KIND_HEADER;
		cand[3].address      = rs2;
		cand[3].payload      = alre_pkg::PAY_W'({ra2, alre_pkg::CODE_W'(rl3)});
		cand[3].offset_value = '0;

		cand[4].kind         = alre_pkg::KIND_TOTAL;
		cand[4].address      = '0;
		cand[4].payload      = wp3[alre_pkg::PAY_W-1:0];
		cand[4].offset_value = wp3;

		cand_en = {pix.image_end, row_done, opaque, close1, ars_q};
	end

	// Pack the enabled candidates into consecutive slots.
	always_comb begin
		logic [alre_pkg::CNT_W-1:0] n;
		n = '0;
		for (int i = 0; i < alre_pkg::MAX_RES; i++) begin
			list[i] = cand[0];
		end
		for (int i = 0; i < 5; i++) begin
			if (cand_en[i] && (n < alre_pkg::CNT_W'(alre_pkg::MAX_RES))) begin
				list[n[alre_pkg::IDX_W-1:0]] = cand[i];
				n = n + alre_pkg::CNT_W'(1);
			end
		end
		count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ra_q  <= '0;
			rl_q  <= '0;
			rs_q  <= '0;
			wp_q  <= '0;
			row_q <= '0;
			ars_q <= 1'b1;
		end else if (advance) begin
			if (pix.image_end) begin
				ra_q  <= '0;
				rl_q  <= '0;
				rs_q  <= '0;
				wp_q  <= '0;
				row_q <= '0;
				ars_q <= 1'b1;
			end else if (pix.row_end) begin
				ra_q  <= ra2;
				rl_q  <= '0;
				rs_q  <= rs2;
				wp_q  <= wp3;
				row_q <= row_q + alre_pkg::ROW_W'(1);
				ars_q <= 1'b1;
			end else begin
				ra_q  <= ra2;
				rl_q  <= rl3;
				rs_q  <= rs2;
				wp_q  <= wp3;
				ars_q <= 1'b0;
			end
		end
	end

	`ALRE_ASSERT_IMP(a_run_bound, 1'b1, rl_q <= alre_pkg::RUN_W'(alre_pkg::MAX_RUN))
	`ALRE_ASSERT_NXT(a_image_reset, advance && pix.image_end, (wp_q == '0) && ars_q && (rl_q == '0))
	`ALRE_ASSERT_NXT(a_row_closes, advance && pix.row_end, (rl_q == '0) && ars_q)
	`ALRE_ASSERT_IMP(a_open_run_mid_row, (rl_q != '0), !ars_q)

endmodule

// File: hdl/alre_obuf.sv
// ----------------------------------------------------------------------------
// alre_obuf: result word buffer of the alpha run-length encoder
// Holds the words of one pixel and sends them out one per handshake.
// ----------------------------------------------------------------------------
`include "alpha_run_length_encoder_assert.svh"

module alre_obuf (
	input  logic                           clk,
	input  logic                           arst_n,
	input  alre_pkg::res_list_t            list,
	input  logic [alre_pkg::CNT_W-1:0]     count,
	input  logic                           load,
	output logic                           can_load,
	output logic                           out_valid,
	input  logic                           out_ready,
	output alre_pkg::res_t                 out_res,
	output logic                           out_last
);

	alre_pkg::res_t                list_q [alre_pkg::MAX_RES];
	logic [alre_pkg::CNT_W-1:0]    cnt_q;
	logic [alre_pkg::IDX_W-1:0]    idx_q;
	logic                          busy;
	logic                          fire;

	always_comb begin
		busy      = cnt_q != '0;
		out_valid = busy;
		out_res   = list_q[idx_q];
		out_last  = alre_pkg::CNT_W'(idx_q) == cnt_q - alre_pkg::CNT_W'(1);
		fire      = busy && out_ready;
		can_load  = !busy || (fire && out_last);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			list_q <= list;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			cnt_q <= count;
			idx_q <= '0;
		end else if (fire) begin
			if (out_last) begin
				cnt_q <= '0;
			end else begin
				idx_q <= idx_q + alre_pkg::IDX_W'(1);
			end
		end
	end

	`ALRE_ASSERT_IMP(a_idx_in_range, busy, alre_pkg::CNT_W'(idx_q) < cnt_q)
	`ALRE_ASSERT_IMP(a_load_when_free, load, can_load)
	`ALRE_ASSERT_NXT(a_load_starts, load && (count != '0), out_valid && (idx_q == '0))
	`ALRE_ASSERT_NXT(a_stall_holds, busy && !out_ready && !load, out_valid && $stable(idx_q))

endmodule

// File: hdl/alpha_run_length_encoder.sv
// A pixel is taken into the input register and its words then into the word buffer.
// Throughput: one pixel per cycle while each pixel yields at most one word and the
// output is ready; a pixel of two to four words holds the buffer until all are sent.
// The output word buffer, which sends one word per handshake, sets the rate.
// Reset (arst_n low) empties both stages and returns the encoder to the start of an
// image: row 0, write offset 0, no open run.
// ----------------------------------------------------------------------------
// alpha_run_length_encoder: run-length packing of RGBA pixels on alpha
// Splits each row into runs of equal alpha (at most 256 pixels) and emits the addressed header and
// RGB writes of the packed area, the row start offsets and the total size.
// ----------------------------------------------------------------------------
module alpha_run_length_encoder (
	input  logic        clk,
	input  logic        arst_n,
	// Pixel input stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16], pixel_alpha[31:24]
	input  logic        s_axis_tlast,   // row_end
	input  logic        s_axis_tuser,   // image_end
	// Result word stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [87:0] m_axis_tdata,   // address[31:0], payload[55:32], offset_value[87:56]
	output logic        m_axis_tlast,   // last word caused by the pixel
	output logic [1:0]  m_axis_tuser    // kind
);

	// Input register: one pixel waiting to be encoded.
	alre_pkg::pixel_t              pix_s1;
	logic                          vld_s1;

	alre_pkg::res_list_t           list;
	logic [alre_pkg::CNT_W-1:0]    count;
	logic                          can_load;
	logic                          advance;
	alre_pkg::res_t                out_res;

	// The held pixel moves on when the word buffer is free or is sending its last
	// word in this cycle; the input register then takes the next pixel at once.
	assign advance       = vld_s1 && can_load;
	assign s_axis_tready = !vld_s1 || advance;

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			pix_s1.red         <= s_axis_tdata[7:0];
			pix_s1.green       <= s_axis_tdata[15:8];
			pix_s1.blue        <= s_axis_tdata[23:16];
			pix_s1.pixel_alpha <= s_axis_tdata[31:24];
			pix_s1.row_end     <= s_axis_tlast;
			pix_s1.image_end   <= s_axis_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	// Run state and the list of words for the held pixel. A transparent pixel
	// inside a run yields an empty list and simply passes through.
	alre_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix     (pix_s1),
		.advance (advance),
		.list    (list),
		.count   (count)
	);

	// Word buffer: the registered result side of the block.
	alre_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.list      (list),
		.count     (count),
		.load      (advance),
		.can_load  (can_load),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {out_res.offset_value, out_res.payload, out_res.address};
	assign m_axis_tuser = out_res.kind;

endmodule
